// ===== design/hhdm_pkg.sv =====
// Shared constants, types and register codes for the heading-hold drive mixer.
package hhdm_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned HEAD_W  = 22;
  localparam int unsigned RATE_W  = 18;
  localparam int unsigned AXIS_W  = 16;
  localparam int unsigned PG_W    = 16;
  localparam int unsigned DG_W    = 24;
  localparam int unsigned RT_W    = 16;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned CFG_AW  = 2;
  localparam int unsigned ERR_W   = HEAD_W + 1;

  // Depth of the queue between the front and back parts.
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QAW     = $clog2(QDEPTH);
  localparam int unsigned QCW     = $clog2(QDEPTH + 1);

  // Hold modes as reported on the result beat.
  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_IMU  = 2'd1;
  localparam logic [1:0] MODE_SAME = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_AW-1:0] CFG_P_GAIN = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_D_GAIN = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_RATIO  = 2'd2;

  // Reset values of the gain registers.
  localparam logic [PG_W-1:0] P_GAIN_RST = 16'd2621;
  localparam logic [DG_W-1:0] D_GAIN_RST = 24'd6711;
  localparam logic [RT_W-1:0] RATIO_RST  = 16'd19661;

  // Q1.15 full scale and the 0.10 minimum turn cap.
  localparam logic signed [AXIS_W-1:0] FULL_SCALE = 16'sd32767;
  localparam logic signed [AXIS_W-1:0] TENTH_Q15  = 16'sd3277;

  // Gain register bank.
  typedef struct packed {
    logic [PG_W-1:0] p_gain;
    logic [DG_W-1:0] d_gain;
    logic [RT_W-1:0] ratio;
  } gains_t;

  // Classified tick as handed from the front part to the back part.
  typedef struct packed {
    logic [1:0]               mode;
    logic signed [ERR_W-1:0]  err;
    logic signed [RATE_W-1:0] rate;
    logic signed [AXIS_W-1:0] fwd;
    logic signed [AXIS_W-1:0] turn;
  } item_t;

endpackage

// ===== design/hhdm_front.sv =====
// Front part: accepts input beats, runs the hold-mode machine and shapes the stick axes.
module hhdm_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [hhdm_pkg::HEAD_W-1:0]   in_heading,
  input  logic signed [hhdm_pkg::RATE_W-1:0]   in_yaw_rate,
  input  logic                                 in_imu_ready,
  input  logic                                 in_hold_button,
  input  logic signed [hhdm_pkg::AXIS_W-1:0]   in_forward_axis,
  input  logic signed [hhdm_pkg::AXIS_W-1:0]   in_turn_axis,
  input  logic                                 q_full,
  output logic                                 q_push,
  output hhdm_pkg::item_t                      q_item
);

  typedef enum logic [1:0] {
    ST_OFF  = hhdm_pkg::MODE_OFF,
    ST_IMU  = hhdm_pkg::MODE_IMU,
    ST_SAME = hhdm_pkg::MODE_SAME
  } state_t;

  state_t                              state_r, state_nxt;
  logic signed [hhdm_pkg::HEAD_W-1:0]  target_r, target_nxt;
  logic                                accept;

  // Negate a raw axis with saturation, then apply the 10% deadband.
  function automatic logic signed [hhdm_pkg::AXIS_W-1:0] shape_axis(
    input logic signed [hhdm_pkg::AXIS_W-1:0] raw
  );
    logic signed [hhdm_pkg::AXIS_W:0]   neg;
    logic signed [hhdm_pkg::AXIS_W-1:0] a;
    neg = -{raw[hhdm_pkg::AXIS_W-1], raw};
    if (neg > 17'sd32767) begin
      a = hhdm_pkg::FULL_SCALE;
    end else begin
      a = neg[hhdm_pkg::AXIS_W-1:0];
    end
    if (a >= hhdm_pkg::TENTH_Q15 || a <= -hhdm_pkg::TENTH_Q15) begin
      return a;
    end
    return '0;
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept;

  // Mode transitions; the target heading latches on entering IMU hold.
  always_comb begin
    state_nxt  = state_r;
    target_nxt = target_r;
    unique case (state_r)
      ST_IMU: begin
        if (!in_hold_button) begin
          state_nxt = ST_OFF;
        end else if (!in_imu_ready) begin
          state_nxt = ST_SAME;
        end
      end
      ST_SAME: begin
        if (!in_hold_button) begin
          state_nxt = ST_OFF;
        end
      end
      default: begin
        state_nxt = ST_OFF;
        if (in_hold_button) begin
          if (!in_imu_ready) begin
            state_nxt = ST_SAME;
          end else begin
            state_nxt  = ST_IMU;
            target_nxt = in_heading;
          end
        end
      end
    endcase
  end

  // Classified beat for the queue.
  always_comb begin
    q_item.mode = state_nxt;
    q_item.err  = {target_nxt[hhdm_pkg::HEAD_W-1], target_nxt}
                - {in_heading[hhdm_pkg::HEAD_W-1], in_heading};
    q_item.rate = in_yaw_rate;
    q_item.fwd  = shape_axis(in_forward_axis);
    q_item.turn = (state_nxt == ST_SAME) ? '0 : shape_axis(in_turn_axis);
  end

  // Mode and target state advance on each accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_OFF;
      target_r <= '0;
    end else if (accept) begin
      state_r  <= state_nxt;
      target_r <= target_nxt;
    end
  end

endmodule

// ===== design/hhdm_queue.sv =====
// Short queue that decouples the front part from the back part.
module hhdm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  hhdm_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output hhdm_pkg::item_t head_item
);

  hhdm_pkg::item_t             mem_r [hhdm_pkg::QDEPTH];
  logic [hhdm_pkg::QAW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [hhdm_pkg::QCW-1:0]    cnt_r;
  logic                        do_push, do_pop;

  assign full      = (cnt_r == hhdm_pkg::QCW'(hhdm_pkg::QDEPTH));
  assign empty     = (cnt_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_item = mem_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == hhdm_pkg::QAW'(hhdm_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == hhdm_pkg::QAW'(hhdm_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== design/hhdm_back.sv =====
// Back part: PD turn, cap, mixing and the output register in a three-stage pipeline.
module hhdm_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  hhdm_pkg::gains_t                   gains,
  input  logic                               q_valid,
  input  hhdm_pkg::item_t                    q_item,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [hhdm_pkg::AXIS_W-1:0] out_left_drive,
  output logic signed [hhdm_pkg::AXIS_W-1:0] out_right_drive,
  output logic [1:0]                         out_hold_mode
);

  // Stage enables.
  logic out_en, s2_en, s1_en;

  // Stage 1: products and turn cap.
  logic                               s1_v_r;
  logic [1:0]                         s1_mode_r;
  logic signed [hhdm_pkg::AXIS_W-1:0] s1_fwd_r, s1_turn_r;
  logic signed [39:0]                 s1_pterm_r;
  logic signed [42:0]                 s1_dterm_r;
  logic [15:0]                        s1_peak_r;

  // Stage 2: rounded and capped turn.
  logic                               s2_v_r;
  logic [1:0]                         s2_mode_r;
  logic signed [hhdm_pkg::AXIS_W-1:0] s2_fwd_r, s2_turn_r;

  // Output register.
  logic                               out_v_r;
  logic [1:0]                         out_mode_r;
  logic signed [hhdm_pkg::AXIS_W-1:0] out_left_r, out_right_r;

  // Stage 1 combinational terms.
  logic signed [39:0]                 pprod;
  logic signed [42:0]                 dprod;
  logic signed [hhdm_pkg::AXIS_W-1:0] fwd_abs;
  logic [30:0]                        rprod;
  logic [31:0]                        rrnd;
  logic [15:0]                        peak;

  // Stage 2 combinational terms.
  logic signed [48:0]                 acc, acc_rnd;
  logic signed [33:0]                 turn_q, peak_s;
  logic signed [hhdm_pkg::AXIS_W-1:0] turn_cap;

  // Output stage combinational terms.
  logic signed [hhdm_pkg::AXIS_W:0]   lsum, rsum;
  logic signed [hhdm_pkg::AXIS_W-1:0] lsat, rsat;

  assign out_en = !out_v_r || out_ready;
  assign s2_en  = !s2_v_r || out_en;
  assign s1_en  = !s1_v_r || s2_en;
  assign q_pop  = q_valid && s1_en;

  // Gain products and the cap peak = max(round(|fwd|*ratio / 2^16), 0.10).
  always_comb begin
    pprod   = q_item.err * $signed({1'b0, gains.p_gain});
    dprod   = q_item.rate * $signed({1'b0, gains.d_gain});
    fwd_abs = q_item.fwd[hhdm_pkg::AXIS_W-1] ? -q_item.fwd : q_item.fwd;
    rprod   = fwd_abs[14:0] * gains.ratio;
    rrnd    = {1'b0, rprod} + 32'd32768;
    peak    = rrnd[31:16];
    if (peak < 16'(hhdm_pkg::TENTH_Q15)) begin
      peak = 16'(hhdm_pkg::TENTH_Q15);
    end
  end

  // PD sum, round half up by 2^15, and clamp to the peak.
  always_comb begin
    acc     = $signed({s1_pterm_r[39], s1_pterm_r, 8'd0}) - 49'(s1_dterm_r);
    acc_rnd = acc + 49'sd16384;
    turn_q  = acc_rnd[48:15];
    peak_s  = $signed({18'd0, s1_peak_r});
    if (turn_q > peak_s) begin
      turn_cap = s1_peak_r;
    end else if (turn_q < -peak_s) begin
      turn_cap = -$signed(s1_peak_r);
    end else begin
      turn_cap = turn_q[hhdm_pkg::AXIS_W-1:0];
    end
  end

  // Differential mix, each side saturated to full scale.
  always_comb begin
    lsum = {s2_fwd_r[hhdm_pkg::AXIS_W-1], s2_fwd_r} - {s2_turn_r[hhdm_pkg::AXIS_W-1], s2_turn_r};
    rsum = {s2_fwd_r[hhdm_pkg::AXIS_W-1], s2_fwd_r} + {s2_turn_r[hhdm_pkg::AXIS_W-1], s2_turn_r};
    if (lsum > 17'sd32767) begin
      lsat = hhdm_pkg::FULL_SCALE;
    end else if (lsum < -17'sd32767) begin
      lsat = -hhdm_pkg::FULL_SCALE;
    end else begin
      lsat = lsum[hhdm_pkg::AXIS_W-1:0];
    end
    if (rsum > 17'sd32767) begin
      rsat = hhdm_pkg::FULL_SCALE;
    end else if (rsum < -17'sd32767) begin
      rsat = -hhdm_pkg::FULL_SCALE;
    end else begin
      rsat = rsum[hhdm_pkg::AXIS_W-1:0];
    end
  end

  // Valid bits of the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_v_r <= q_valid;
      end
      if (s2_en) begin
        s2_v_r <= s1_v_r;
      end
      if (out_en) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // Payload registers of the pipeline.
  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_mode_r  <= q_item.mode;
      s1_fwd_r   <= q_item.fwd;
      s1_turn_r  <= q_item.turn;
      s1_pterm_r <= pprod;
      s1_dterm_r <= dprod;
      s1_peak_r  <= peak;
    end
    if (s2_en) begin
      s2_mode_r <= s1_mode_r;
      s2_fwd_r  <= s1_fwd_r;
      s2_turn_r <= (s1_mode_r == hhdm_pkg::MODE_IMU) ? turn_cap : s1_turn_r;
    end
    if (out_en) begin
      out_mode_r  <= s2_mode_r;
      out_left_r  <= lsat;
      out_right_r <= -rsat;
    end
  end

  assign out_valid       = out_v_r;
  assign out_left_drive  = out_left_r;
  assign out_right_drive = out_right_r;
  assign out_hold_mode   = out_mode_r;

endmodule

// ===== design/heading_hold_drive_mixer_core.sv =====
// Heading-hold drive mixer: top level with gain registers, front, queue and back.
// Path: a beat accepted at one edge is written into the queue, then passes stage 1,
// stage 2 and the output register before it shows on out_valid; output stalls add to this.
// Throughput: one beat per cycle; the front stalls only when the two-entry queue is full.
// Reset (rst_n low, synchronous) puts the hold mode off, the target heading at zero,
// empties the queue and pipeline, and loads the gain registers with their defaults.
module heading_hold_drive_mixer_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [hhdm_pkg::HEAD_W-1:0]  in_heading,
  input  logic signed [hhdm_pkg::RATE_W-1:0]  in_yaw_rate,
  input  logic                                in_imu_ready,
  input  logic                                in_hold_button,
  input  logic signed [hhdm_pkg::AXIS_W-1:0]  in_forward_axis,
  input  logic signed [hhdm_pkg::AXIS_W-1:0]  in_turn_axis,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [hhdm_pkg::AXIS_W-1:0]  out_left_drive,
  output logic signed [hhdm_pkg::AXIS_W-1:0]  out_right_drive,
  output logic [1:0]                          out_hold_mode,
  input  logic                                cfg_we,
  input  logic [hhdm_pkg::CFG_AW-1:0]         cfg_index,
  input  logic [hhdm_pkg::CFG_W-1:0]          cfg_data
);

  hhdm_pkg::gains_t gains_r;
  hhdm_pkg::item_t  push_item, head_item;
  logic             q_push, q_pop, q_full, q_empty;

  // Gain registers; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r.p_gain <= hhdm_pkg::P_GAIN_RST;
      gains_r.d_gain <= hhdm_pkg::D_GAIN_RST;
      gains_r.ratio  <= hhdm_pkg::RATIO_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hhdm_pkg::CFG_P_GAIN: gains_r.p_gain <= cfg_data[hhdm_pkg::PG_W-1:0];
        hhdm_pkg::CFG_D_GAIN: gains_r.d_gain <= cfg_data[hhdm_pkg::DG_W-1:0];
        hhdm_pkg::CFG_RATIO:  gains_r.ratio  <= cfg_data[hhdm_pkg::RT_W-1:0];
        default: ;
      endcase
    end
  end

  hhdm_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_heading      (in_heading),
    .in_yaw_rate     (in_yaw_rate),
    .in_imu_ready    (in_imu_ready),
    .in_hold_button  (in_hold_button),
    .in_forward_axis (in_forward_axis),
    .in_turn_axis    (in_turn_axis),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_item          (push_item)
  );

  hhdm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head_item (head_item)
  );

  hhdm_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .gains           (gains_r),
    .q_valid         (!q_empty),
    .q_item          (head_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_left_drive  (out_left_drive),
    .out_right_drive (out_right_drive),
    .out_hold_mode   (out_hold_mode)
  );

  // Same-throttle mode drives both sides from one saturated value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hold_mode == hhdm_pkg::MODE_SAME |-> out_left_drive == -out_right_drive)
    else $error("same-throttle beat with unequal sides");

  // Saturation never lets a side reach the most negative code.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_left_drive != 16'sh8000 && out_right_drive != 16'sh8000)
    else $error("drive outside full scale");

  // The queue is never pushed while full.
  assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue overflow");

  // A pop only happens when the queue holds an entry.
  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue underflow");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the heading-hold drive mixer: random handshakes, predicted drive.
`timescale 1ns / 1ps

module tb_top;

  // One control tick as driven on the input channel.
  typedef struct {
    logic signed [hhdm_pkg::HEAD_W-1:0] heading;
    logic signed [hhdm_pkg::RATE_W-1:0] yaw_rate;
    logic                               imu_ready;
    logic                               hold_button;
    logic signed [hhdm_pkg::AXIS_W-1:0] forward_axis;
    logic signed [hhdm_pkg::AXIS_W-1:0] turn_axis;
  } tick_t;

  // One motor command beat as seen on the result channel.
  typedef struct {
    logic signed [hhdm_pkg::AXIS_W-1:0] left_drive;
    logic signed [hhdm_pkg::AXIS_W-1:0] right_drive;
    logic [1:0]                         hold_mode;
  } drive_t;

  localparam int          HEADING_SPAN = 1474560;
  localparam int          RATE_SPAN    = 128000;
  localparam int          PHASE_TICKS  = 230;
  localparam int          STALL_LIMIT  = 2000;
  localparam int          DRAIN_CYCLES = 8;
  localparam longint      DEADBAND_TEN = 32768;
  localparam longint      Q15_HALF     = 16384;
  localparam longint      Q16_HALF     = 32768;
  localparam logic [hhdm_pkg::CFG_AW-1:0] CFG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic signed [hhdm_pkg::HEAD_W-1:0] in_heading = '0;
  logic signed [hhdm_pkg::RATE_W-1:0] in_yaw_rate = '0;
  logic                               in_imu_ready = 1'b0;
  logic                               in_hold_button = 1'b0;
  logic signed [hhdm_pkg::AXIS_W-1:0] in_forward_axis = '0;
  logic signed [hhdm_pkg::AXIS_W-1:0] in_turn_axis = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic signed [hhdm_pkg::AXIS_W-1:0] out_left_drive;
  logic signed [hhdm_pkg::AXIS_W-1:0] out_right_drive;
  logic [1:0]                         out_hold_mode;
  logic                               cfg_we = 1'b0;
  logic [hhdm_pkg::CFG_AW-1:0]        cfg_index = '0;
  logic [hhdm_pkg::CFG_W-1:0]         cfg_data = '0;

  // Stimulus and prediction bookkeeping.
  tick_t       pending_ticks[$];
  drive_t      predicted_drives[$];
  tick_t       drive_tick;
  tick_t       seen_tick;
  drive_t      want;
  int unsigned ticks_queued = 0;
  int unsigned ticks_accepted = 0;
  int unsigned fail_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        in_beat_taken = 1'b0;

  // Predictor state, mirrored from what the block should hold.
  logic [1:0]                         mode_q = hhdm_pkg::MODE_OFF;
  logic signed [hhdm_pkg::HEAD_W-1:0] target_q = '0;
  hhdm_pkg::gains_t                   gains_q = '{p_gain: hhdm_pkg::P_GAIN_RST,
                                                  d_gain: hhdm_pkg::D_GAIN_RST,
                                                  ratio:  hhdm_pkg::RATIO_RST};

  heading_hold_drive_mixer_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_heading      (in_heading),
    .in_yaw_rate     (in_yaw_rate),
    .in_imu_ready    (in_imu_ready),
    .in_hold_button  (in_hold_button),
    .in_forward_axis (in_forward_axis),
    .in_turn_axis    (in_turn_axis),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_left_drive  (out_left_drive),
    .out_right_drive (out_right_drive),
    .out_hold_mode   (out_hold_mode),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Negate a raw stick axis, saturate the one overflow case and apply the 10% deadband.
  function automatic longint shape_axis(input logic signed [hhdm_pkg::AXIS_W-1:0] raw);
    longint a;
    a = -longint'(raw);
    if (a > longint'(hhdm_pkg::FULL_SCALE)) begin
      a = longint'(hhdm_pkg::FULL_SCALE);
    end
    if (10 * a > DEADBAND_TEN || 10 * a < -DEADBAND_TEN) begin
      return a;
    end
    return 0;
  endfunction

  function automatic longint clamp_sym(input longint v, input longint peak);
    if (v < -peak) begin
      return -peak;
    end
    if (v > peak) begin
      return peak;
    end
    return v;
  endfunction

  // Advance the hold-mode machine by one tick and work out the motor commands.
  function automatic drive_t mix_drive(input tick_t t);
    drive_t d;
    longint fwd, turn, err, acc, mag, peak, left, right;
    fwd  = shape_axis(t.forward_axis);
    turn = shape_axis(t.turn_axis);
    case (mode_q)
      hhdm_pkg::MODE_IMU: begin
        if (!t.hold_button) begin
          mode_q = hhdm_pkg::MODE_OFF;
        end else if (!t.imu_ready) begin
          mode_q = hhdm_pkg::MODE_SAME;
        end
      end
      hhdm_pkg::MODE_SAME: begin
        if (!t.hold_button) begin
          mode_q = hhdm_pkg::MODE_OFF;
        end
      end
      default: begin
        mode_q = hhdm_pkg::MODE_OFF;
        if (t.hold_button) begin
          if (!t.imu_ready) begin
            mode_q = hhdm_pkg::MODE_SAME;
          end else begin
            mode_q   = hhdm_pkg::MODE_IMU;
            target_q = t.heading;
          end
        end
      end
    endcase

    // PD correction, rounded half up from Q15, capped by the forward throttle.
    if (mode_q == hhdm_pkg::MODE_IMU) begin
      err  = longint'(target_q) - longint'(t.heading);
      acc  = err * longint'(gains_q.p_gain) * 256
             - longint'(t.yaw_rate) * longint'(gains_q.d_gain);
      mag  = (fwd < 0) ? -fwd : fwd;
      peak = (mag * longint'(gains_q.ratio) + Q16_HALF) >>> 16;
      if (peak < longint'(hhdm_pkg::TENTH_Q15)) begin
        peak = longint'(hhdm_pkg::TENTH_Q15);
      end
      turn = clamp_sym((acc + Q15_HALF) >>> 15, peak);
    end else if (mode_q == hhdm_pkg::MODE_SAME) begin
      turn = 0;
    end

    left  = clamp_sym(fwd - turn, longint'(hhdm_pkg::FULL_SCALE));
    right = -clamp_sym(fwd + turn, longint'(hhdm_pkg::FULL_SCALE));
    d.left_drive  = left[hhdm_pkg::AXIS_W-1:0];
    d.right_drive = right[hhdm_pkg::AXIS_W-1:0];
    d.hold_mode   = mode_q;
    return d;
  endfunction

  function automatic void compare_field(input string name,
                                        input logic signed [hhdm_pkg::AXIS_W-1:0] exp_v,
                                        input logic signed [hhdm_pkg::AXIS_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  function automatic int rand_signed(input int unsigned span);
    return int'($urandom_range(2 * span)) - int'(span);
  endfunction

  // Stick values: a quarter of them straddle the deadband edges.
  function automatic logic signed [hhdm_pkg::AXIS_W-1:0] rand_axis();
    if ($urandom_range(3) == 0) begin
      return hhdm_pkg::AXIS_W'(rand_signed(3500));
    end
    return hhdm_pkg::AXIS_W'($urandom);
  endfunction

  function automatic void queue_tick(input int heading, input int yaw_rate, input logic imu_ready,
                                     input logic hold_button,
                                     input logic [hhdm_pkg::AXIS_W-1:0] forward_axis,
                                     input logic [hhdm_pkg::AXIS_W-1:0] turn_axis);
    tick_t t;
    t.heading      = hhdm_pkg::HEAD_W'(heading);
    t.yaw_rate     = hhdm_pkg::RATE_W'(yaw_rate);
    t.imu_ready    = imu_ready;
    t.hold_button  = hold_button;
    t.forward_axis = forward_axis;
    t.turn_axis    = turn_axis;
    pending_ticks.push_back(t);
    ticks_queued++;
  endfunction

  // Mostly hold episodes around a latched heading, with some loose noise ticks.
  task automatic queue_episodes(input int unsigned n_ticks);
    int unsigned made;
    int unsigned run_len;
    int          base;
    int unsigned err_span;
    int unsigned rate_span;
    logic        hold;
    logic        ready;
    made = 0;
    while (made < n_ticks) begin
      if ($urandom_range(9) == 0) begin
        queue_tick(rand_signed(HEADING_SPAN), rand_signed(RATE_SPAN), 1'($urandom_range(1)),
                   1'($urandom_range(1)), hhdm_pkg::AXIS_W'($urandom),
                   hhdm_pkg::AXIS_W'($urandom));
        made++;
      end else begin
        run_len = $urandom_range(2, 24);
        base    = rand_signed(HEADING_SPAN - 60000);
        case ($urandom_range(2))
          0: begin
            err_span  = 60;
            rate_span = 100;
          end
          1: begin
            err_span  = 600;
            rate_span = 4000;
          end
          default: begin
            err_span  = 50000;
            rate_span = RATE_SPAN;
          end
        endcase
        for (int k = 0; k < run_len; k++) begin
          hold  = (k != run_len - 1) && ($urandom_range(15) != 0);
          ready = ($urandom_range(11) != 0);
          queue_tick(base + rand_signed(err_span), rand_signed(rate_span), ready, hold,
                     rand_axis(), rand_axis());
        end
        made += run_len;
      end
    end
  endtask

  // Returns once every queued tick has been accepted and every drive beat has come back.
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (ticks_accepted != ticks_queued || predicted_drives.size() != 0);
  endtask

  task automatic write_gain(input logic [hhdm_pkg::CFG_AW-1:0] idx,
                            input logic [hhdm_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    case (idx)
      hhdm_pkg::CFG_P_GAIN: gains_q.p_gain = value[hhdm_pkg::PG_W-1:0];
      hhdm_pkg::CFG_D_GAIN: gains_q.d_gain = value[hhdm_pkg::DG_W-1:0];
      hhdm_pkg::CFG_RATIO:  gains_q.ratio  = value[hhdm_pkg::RT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_gains(input logic [hhdm_pkg::CFG_W-1:0] p,
                           input logic [hhdm_pkg::CFG_W-1:0] d,
                           input logic [hhdm_pkg::CFG_W-1:0] ratio);
    write_gain(hhdm_pkg::CFG_P_GAIN, p);
    write_gain(hhdm_pkg::CFG_D_GAIN, d);
    write_gain(hhdm_pkg::CFG_RATIO, ratio);
  endtask

  task automatic run_phase(input int unsigned sender_pct, input int unsigned receiver_pct);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    queue_episodes(PHASE_TICKS);
    wait_drained();
  endtask

  // Input driver: a new tick goes out only after the previous beat was taken.
  always @(negedge clk) begin
    if (!in_valid || in_beat_taken) begin
      if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_tick       = pending_ticks.pop_front();
        in_heading      <= drive_tick.heading;
        in_yaw_rate     <= drive_tick.yaw_rate;
        in_imu_ready    <= drive_tick.imu_ready;
        in_hold_button  <= drive_tick.hold_button;
        in_forward_axis <= drive_tick.forward_axis;
        in_turn_axis    <= drive_tick.turn_axis;
        in_valid        <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: check drive beats against the oldest prediction, predict accepted ticks.
  always @(posedge clk) begin
    in_beat_taken = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (predicted_drives.size() == 0) begin
          $error("drive beat with no prediction waiting: left %0d, right %0d, mode %0d",
                 out_left_drive, out_right_drive, out_hold_mode);
          fail_count++;
        end else begin
          want = predicted_drives.pop_front();
          compare_field("left_drive", want.left_drive, out_left_drive);
          compare_field("right_drive", want.right_drive, out_right_drive);
          compare_field("hold_mode", hhdm_pkg::AXIS_W'(want.hold_mode),
                        hhdm_pkg::AXIS_W'(out_hold_mode));
        end
      end
      if (in_valid && in_ready) begin
        seen_tick.heading      = in_heading;
        seen_tick.yaw_rate     = in_yaw_rate;
        seen_tick.imu_ready    = in_imu_ready;
        seen_tick.hold_button  = in_hold_button;
        seen_tick.forward_axis = in_forward_axis;
        seen_tick.turn_axis    = in_turn_axis;
        predicted_drives.push_back(mix_drive(seen_tick));
        ticks_accepted++;
        in_beat_taken = 1'b1;
      end
    end

    // Watchdog counter: only cycles with work outstanding and no beat moving count.
    if (in_beat_taken || (out_valid && out_ready)
        || (ticks_accepted == ticks_queued && predicted_drives.size() == 0)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("heading_hold_drive_mixer_core: mismatch");
    $finish;
  end

  initial begin
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Directed ticks at reset gains.
    send_idle_pct = 17;
    recv_idle_pct = 49;
    // Stick extremes and deadband edges with hold released.
    queue_tick(0, 0, 1'b1, 1'b0, 16'sh8000, 16'sh7FFF);
    queue_tick(0, 0, 1'b1, 1'b0, 16'sh7FFF, 16'sh8000);
    queue_tick(0, 0, 1'b0, 1'b0, -3277, -3276);
    queue_tick(0, 0, 1'b0, 1'b0, 3277, 3276);
    // Hold with a ready IMU at the top heading, then large errors and rates.
    queue_tick(HEADING_SPAN, 0, 1'b1, 1'b1, -16000, 0);
    queue_tick(-HEADING_SPAN, RATE_SPAN, 1'b1, 1'b1, -16000, 0);
    queue_tick(HEADING_SPAN - 100, -RATE_SPAN, 1'b1, 1'b1, 16'sh8000, 0);
    queue_tick(HEADING_SPAN - 40, 0, 1'b1, 1'b1, 0, 0);
    // IMU drops out while held and comes back: the mode stays same-throttle.
    queue_tick(HEADING_SPAN, 0, 1'b0, 1'b1, -20000, -8000);
    queue_tick(HEADING_SPAN, 0, 1'b1, 1'b1, -20000, -8000);
    queue_tick(0, 0, 1'b1, 1'b0, -20000, 0);
    // Hold entered without an IMU goes straight to same-throttle.
    queue_tick(0, 0, 1'b0, 1'b1, 20000, 20000);
    queue_tick(0, 0, 1'b0, 1'b0, 20000, 0);
    // Zero forward throttle leaves only the minimum turn cap.
    queue_tick(0, 0, 1'b1, 1'b1, 0, 0);
    queue_tick(200, 0, 1'b1, 1'b1, 0, 0);
    queue_tick(-200, 5000, 1'b1, 1'b1, 0, 0);
    queue_tick(-3, -7, 1'b1, 1'b1, 16'sh8000, 0);
    queue_tick(0, 0, 1'b1, 1'b0, 0, 0);
    // Bottom heading latched, small errors exercise the rounding.
    queue_tick(-HEADING_SPAN, 0, 1'b1, 1'b1, -32767, 32767);
    queue_tick(-HEADING_SPAN + 37, -37, 1'b1, 1'b1, 32767, -32767);
    queue_tick(-HEADING_SPAN + 1, 1, 1'b1, 1'b1, 16'sh8000, 0);
    queue_tick(0, 0, 1'b0, 0, 0, 0);
    wait_drained();

    // Largest gains; the P gain and ratio writes carry junk above their register widths.
    set_gains(24'hFF_FFFF, 24'hFF_FFFF, 24'hAB_FFFF);
    run_phase(17, 49);

    // Zero gains; a write to the unused index must change nothing.
    set_gains('0, '0, '0);
    write_gain(CFG_UNUSED, hhdm_pkg::CFG_W'($urandom));
    run_phase(17, 49);

    // Sender-side idling with the reset gains back, then moderate random gains.
    set_gains(hhdm_pkg::CFG_W'(hhdm_pkg::P_GAIN_RST), hhdm_pkg::CFG_W'(hhdm_pkg::D_GAIN_RST),
              hhdm_pkg::CFG_W'(hhdm_pkg::RATIO_RST));
    run_phase(49, 17);
    set_gains(hhdm_pkg::CFG_W'($urandom_range(8000)), hhdm_pkg::CFG_W'($urandom_range(60000)),
              hhdm_pkg::CFG_W'($urandom));
    run_phase(49, 17);

    // Back-to-back beats: fully random gains, then moderate ones.
    set_gains(hhdm_pkg::CFG_W'($urandom), hhdm_pkg::CFG_W'($urandom),
              hhdm_pkg::CFG_W'($urandom));
    run_phase(0, 0);
    set_gains(hhdm_pkg::CFG_W'($urandom_range(8000)), hhdm_pkg::CFG_W'($urandom_range(60000)),
              hhdm_pkg::CFG_W'($urandom));
    run_phase(0, 0);

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("heading_hold_drive_mixer_core: match");
    end else begin
      $display("heading_hold_drive_mixer_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/hhdm_pkg.sv
design/hhdm_front.sv
design/hhdm_queue.sv
design/hhdm_back.sv
design/heading_hold_drive_mixer_core.sv
test/tb_top.sv
